@@ rtl/core/srs_pkg.sv @@
`default_nettype none

package srs_pkg;

	localparam int OFF_W = 48;
	localparam int LEN_W = 22;
	localparam int CHUNK_W = 33;
	localparam int TCNT_W = 5;
	localparam int TIDX_W = 4;
	localparam int MUL_SLICE = 16;
	localparam int MUL_STAGES = OFF_W / MUL_SLICE;

	localparam logic [0:0] REG_CHUNK_SIZE = 1'b0;
	localparam logic [0:0] REG_TARGET_COUNT = 1'b1;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		logic [CHUNK_W-1:0] chunk;
		logic [TCNT_W-1:0] tcnt;
		logic [CHUNK_W-1:0] rem;
		logic [TCNT_W-1:0] rem2;
		logic [OFF_W-1:0] row;
	} div_t;

	typedef struct packed {
		logic [OFF_W-1:0] acc;
		logic [OFF_W-1:0] row;
		logic [CHUNK_W-1:0] chunk_off;
		logic [TCNT_W-1:0] tgt;
		logic [LEN_W-1:0] len;
		logic [CHUNK_W-1:0] chunk;
		logic [TCNT_W-1:0] tcnt;
	} mul_t;

endpackage

`default_nettype wire

@@ rtl/core/stripe_request_splitter.sv @@
// Splits a byte request into the stripe chunks that it touches.
// Input channel (in_valid/in_ready): start_offset and request_length.
// Output channel (out_valid/out_ready): one transaction per piece, with the
// target, the target-local offset, the piece length, its position within
// the request and a last_piece flag on the final one. At most MAX_PIECES
// pieces are given per request; an empty request gives none.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 is chunk_size,
// index 1 is target_count. Write only while the block is idle.
// A request first passes a 48-stage pipelined divider, which finds the chunk
// index, the offset within the chunk, the target and the stripe row one
// quotient bit per stage, and then three multiplier stages that form the
// row base. Pieces then leave the generator through the output register,
// one per cycle while the receiver takes them. A request of N pieces holds
// the generator until its last piece, and the front pipeline accepts a new
// request every cycle while the generator can take its oldest entry.
// When the receiver stalls, the output register holds its piece, the
// generator and then the whole front pipeline stall; nothing is lost.
// Reset clears all valid flags and loads chunk_size 524288, target_count 4.
`default_nettype none

module stripe_request_splitter
	import srs_pkg::*;
#(
	parameter int MAX_TARGETS = 16,
	parameter int MAX_PIECES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [OFF_W-1:0] start_offset,
	input  wire logic [LEN_W-1:0] request_length,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [TIDX_W-1:0] target_index,
	output logic [OFF_W-1:0] local_offset,
	output logic [LEN_W-1:0] piece_length,
	output logic [LEN_W-1:0] request_position,
	output logic last_piece,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [0:0] cfg_index,
	input  wire logic [63:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_PIECES);

	logic [CHUNK_W-1:0] chunk_q;
	logic [TCNT_W-1:0] tcnt_q;

	div_t ds_s1 [OFF_W];
	logic dv_s1 [OFF_W];
	mul_t ms_s2 [MUL_STAGES];
	logic mv_s2 [MUL_STAGES];

	div_t entry;
	logic adv;
	logic load;

	logic busy_q;
	logic [OFF_W-1:0] base_q;
	logic [CHUNK_W-1:0] chunk_off_q;
	logic [TCNT_W-1:0] tgt_q;
	logic [TCNT_W-1:0] gtcnt_q;
	logic [CHUNK_W-1:0] gchunk_q;
	logic [LEN_W-1:0] remain_q;
	logic [LEN_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CHUNK_W:0] span;
	logic [LEN_W-1:0] plen;
	logic [LEN_W-1:0] remain_n;
	logic plast;
	logic emit;
	logic wrap;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= CHUNK_W'(524288);
			tcnt_q <= TCNT_W'(4);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CHUNK_SIZE: chunk_q <= cfg_data[CHUNK_W-1:0];
				REG_TARGET_COUNT: tcnt_q <= cfg_data[TCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		entry = '0;
		entry.off = start_offset;
		entry.len = request_length;
		entry.chunk = (chunk_q == '0) ? CHUNK_W'(1) : chunk_q;
		if (tcnt_q == '0)
			entry.tcnt = TCNT_W'(1);
		else if (MAX_TARGETS < 32 && tcnt_q > TCNT_W'(MAX_TARGETS))
			entry.tcnt = TCNT_W'(MAX_TARGETS);
		else
			entry.tcnt = tcnt_q;
	end

	assign load = mv_s2[MUL_STAGES-1] && !busy_q;
	assign adv = !mv_s2[MUL_STAGES-1] || !busy_q;
	assign in_ready = adv;

	for (genvar i = 0; i < OFF_W; i++) begin : g_div
		div_t prev;
		logic pv;
		logic [CHUNK_W:0] t1;
		logic [CHUNK_W:0] d1;
		logic ge1;
		logic [TCNT_W:0] t2;
		logic [TCNT_W:0] d2;
		logic ge2;
		div_t nxt;

		if (i == 0) begin : g_first
			assign prev = entry;
			assign pv = in_valid;
		end else begin : g_rest
			assign prev = ds_s1[i-1];
			assign pv = dv_s1[i-1];
		end

		always_comb begin
			nxt = prev;
			t1 = {prev.rem, prev.off[OFF_W-1-i]};
			d1 = t1 - {1'b0, prev.chunk};
			ge1 = t1 >= {1'b0, prev.chunk};
			nxt.rem = ge1 ? d1[CHUNK_W-1:0] : t1[CHUNK_W-1:0];
			t2 = {prev.rem2, ge1};
			d2 = t2 - {1'b0, prev.tcnt};
			ge2 = t2 >= {1'b0, prev.tcnt};
			nxt.rem2 = ge2 ? d2[TCNT_W-1:0] : t2[TCNT_W-1:0];
			nxt.row = {prev.row[OFF_W-2:0], ge2};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s1[i] <= 1'b0;
			end else if (adv) begin
				dv_s1[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				ds_s1[i] <= nxt;
		end
	end

	for (genvar k = 0; k < MUL_STAGES; k++) begin : g_mul
		mul_t prev;
		logic pv;
		logic [MUL_SLICE+CHUNK_W-1:0] pp;
		mul_t nxt;

		if (k == 0) begin : g_first
			always_comb begin
				prev.acc = '0;
				prev.row = ds_s1[OFF_W-1].row;
				prev.chunk_off = ds_s1[OFF_W-1].rem;
				prev.tgt = ds_s1[OFF_W-1].rem2;
				prev.len = ds_s1[OFF_W-1].len;
				prev.chunk = ds_s1[OFF_W-1].chunk;
				prev.tcnt = ds_s1[OFF_W-1].tcnt;
			end
			assign pv = dv_s1[OFF_W-1];
		end else begin : g_rest
			assign prev = ms_s2[k-1];
			assign pv = mv_s2[k-1];
		end

		always_comb begin
			nxt = prev;
			pp = prev.row[k*MUL_SLICE +: MUL_SLICE] * prev.chunk;
			nxt.acc = prev.acc + (OFF_W'(pp) << (k * MUL_SLICE));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mv_s2[k] <= 1'b0;
			end else if (adv) begin
				mv_s2[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				ms_s2[k] <= nxt;
		end
	end

	always_comb begin
		span = {1'b0, gchunk_q} - {1'b0, chunk_off_q};
		if (span < {{(CHUNK_W+1-LEN_W){1'b0}}, remain_q})
			plen = span[LEN_W-1:0];
		else
			plen = remain_q;
		remain_n = remain_q - plen;
		plast = (remain_n == '0) || (cnt_q == CNT_W'(MAX_PIECES - 1));
		wrap = (tgt_q + TCNT_W'(1)) == gtcnt_q;
		emit = busy_q && (!out_valid || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
				if (plast)
					busy_q <= 1'b0;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (load)
				busy_q <= ms_s2[MUL_STAGES-1].len != '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			base_q <= ms_s2[MUL_STAGES-1].acc;
			chunk_off_q <= ms_s2[MUL_STAGES-1].chunk_off;
			tgt_q <= ms_s2[MUL_STAGES-1].tgt;
			gtcnt_q <= ms_s2[MUL_STAGES-1].tcnt;
			gchunk_q <= ms_s2[MUL_STAGES-1].chunk;
			remain_q <= ms_s2[MUL_STAGES-1].len;
			pos_q <= '0;
			cnt_q <= '0;
		end else if (emit) begin
			target_index <= tgt_q[TIDX_W-1:0];
			local_offset <= base_q + OFF_W'(chunk_off_q);
			piece_length <= plen;
			request_position <= pos_q;
			last_piece <= plast;
			chunk_off_q <= '0;
			remain_q <= remain_n;
			pos_q <= pos_q + plen;
			cnt_q <= cnt_q + CNT_W'(1);
			if (wrap) begin
				tgt_q <= '0;
				base_q <= base_q + OFF_W'(gchunk_q);
			end else begin
				tgt_q <= tgt_q + TCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/srs_checker.sv @@
`default_nettype none

module srs_checker
	import srs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [LEN_W-1:0] piece_length,
	input wire logic [LEN_W-1:0] request_position,
	input wire logic last_piece
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(request_position))
		else $error("Stalled output transaction changed.");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> piece_length != '0)
		else $error("Empty piece emitted.");

	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_piece |=> out_valid)
		else $error("Pieces of a request were not contiguous in time.");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_piece |=>
		request_position == $past(request_position + piece_length))
		else $error("Piece position does not follow the previous piece.");

endmodule

bind stripe_request_splitter srs_checker u_srs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.piece_length(piece_length),
	.request_position(request_position),
	.last_piece(last_piece)
);

`default_nettype wire
